// ===== sv/lurf_pkg.sv =====
// Package with the shared types and constants of the longest unique run finder.
`default_nettype none
package lurf_pkg;
   // Longest string handled; characters beyond it are dropped and flagged.
   localparam int MAX_LEN = 65536;
   // Width of a stored character offset and of the position counter.
   localparam int LP_W = $clog2(MAX_LEN);
   localparam int POS_W = $clog2(MAX_LEN + 1);

   // Character alphabet.
   localparam int CHAR_W = 8;
   localparam int CHARS = 1 << CHAR_W;

   // Result field widths.
   localparam int START_W = 16;
   localparam int LEN_W = 17;
   localparam int RSP_DATA_W = ((START_W + LEN_W + 7) / 8) * 8;

   // Queue between front and back.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // One queued item.
   typedef struct packed {
      logic [CHAR_W-1:0] char_byte;
      logic              has_char;
      logic              last;
   } lurf_item_type;

   // Handshake from the queue to the back end.
   typedef struct packed {
      logic          valid;
      lurf_item_type item;
   } lurf_queue_type;
endpackage
`default_nettype wire

// ===== sv/lurf_front.sv =====
// Front end: accepts items, drops items that have no effect, and queues the rest.
`default_nettype none
module lurf_front (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   input  wire logic [lurf_pkg::CHAR_W-1:0] in_char,
   input  wire logic                        in_has_char,
   input  wire logic                        in_last,
   output lurf_pkg::lurf_queue_type         queue_head,
   input  wire logic                        queue_pop
);
   import lurf_pkg::*;

   lurf_item_type     slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              accept;
   logic              keep;
   logic              push;

   // An item without a character that does not end a string changes nothing.
   assign req_tready = (count_ff != QCNT_W'(QDEPTH));
   assign accept     = req_tvalid && req_tready;
   assign keep       = in_has_char || in_last;
   assign push       = accept && keep;

   assign queue_head = '{valid: (count_ff != '0), item: slot_ff[rd_ptr_ff]};

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = queue_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !queue_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push && queue_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{char_byte: in_char, has_char: in_has_char, last: in_last};
      end
   end
endmodule
`default_nettype wire

// ===== sv/lurf_back.sv =====
// Back end: position table, window tracking and the result register.
`default_nettype none
module lurf_back (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire lurf_pkg::lurf_queue_type     queue_head,
   output logic                              queue_pop,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [lurf_pkg::START_W-1:0]      rsp_start,
   output logic [lurf_pkg::LEN_W-1:0]        rsp_length,
   output logic                              rsp_overflow
);
   import lurf_pkg::*;

   // Last offset of each character; contents undefined until written.
   logic [LP_W-1:0]  last_pos_mem [CHARS];
   logic [CHARS-1:0] seen_ff, seen_in;

   // Execute stage holding register.
   logic             ex_valid_ff, ex_valid_in;
   lurf_item_type    ex_item_ff;
   logic [LP_W-1:0]  rd_data_ff;
   logic             fwd_ff, fwd_in;
   logic [LP_W-1:0]  fwd_pos_ff;

   // Per-string state.
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [LP_W-1:0]  ws_ff, ws_in;
   logic [LP_W-1:0]  best_start_ff, best_start_in;
   logic [POS_W-1:0] best_len_ff, best_len_in;
   logic             ovf_ff, ovf_in;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [START_W-1:0] rsp_start_ff;
   logic [LEN_W-1:0]   rsp_length_ff;
   logic               rsp_overflow_ff;

   logic             ex_go;
   logic [LP_W-1:0]  prev_pos;
   logic             in_range;
   logic             do_char;
   logic             repeat_hit;
   logic [POS_W-1:0] cand_repeat;
   logic             better_repeat;
   logic [LP_W-1:0]  start_mid;
   logic [POS_W-1:0] len_mid;
   logic [LP_W-1:0]  ws_next;
   logic [POS_W-1:0] pos_next;
   logic [POS_W-1:0] cand_final;
   logic             better_final;
   logic [LP_W-1:0]  final_start;
   logic [POS_W-1:0] final_len;

   // A string end waits for the result register to be free.
   assign ex_go     = ex_valid_ff &&
                      (!ex_item_ff.last || !rsp_valid_ff || rsp_ready);
   assign queue_pop = queue_head.valid && (!ex_valid_ff || ex_go);

   // Window and best-run arithmetic for the item in the execute stage.
   always_comb begin
      prev_pos      = fwd_ff ? fwd_pos_ff : rd_data_ff;
      in_range      = (pos_ff < POS_W'(MAX_LEN));
      do_char       = ex_item_ff.has_char && in_range;
      repeat_hit    = do_char && seen_ff[ex_item_ff.char_byte] && (prev_pos >= ws_ff);
      cand_repeat   = pos_ff - POS_W'(ws_ff);
      better_repeat = repeat_hit && (cand_repeat > best_len_ff);
      start_mid     = better_repeat ? ws_ff : best_start_ff;
      len_mid       = better_repeat ? cand_repeat : best_len_ff;
      ws_next       = repeat_hit ? prev_pos + LP_W'(1) : ws_ff;
      pos_next      = do_char ? pos_ff + POS_W'(1) : pos_ff;
      cand_final    = pos_next - POS_W'(ws_next);
      better_final  = cand_final > len_mid;
      final_start   = better_final ? ws_next : start_mid;
      final_len     = better_final ? cand_final : len_mid;
   end

   // Next state of the string registers and seen flags.
   always_comb begin
      pos_in        = pos_ff;
      ws_in         = ws_ff;
      best_start_in = best_start_ff;
      best_len_in   = best_len_ff;
      ovf_in        = ovf_ff;
      seen_in       = seen_ff;
      if (ex_go) begin
         if (ex_item_ff.last) begin
            pos_in        = '0;
            ws_in         = '0;
            best_start_in = '0;
            best_len_in   = '0;
            ovf_in        = 1'b0;
            seen_in       = '0;
         end else begin
            pos_in        = pos_next;
            ws_in         = ws_next;
            best_start_in = start_mid;
            best_len_in   = len_mid;
            ovf_in        = ovf_ff || (ex_item_ff.has_char && !in_range);
            if (do_char) begin
               seen_in[ex_item_ff.char_byte] = 1'b1;
            end
         end
      end
   end

   // Stage control and forwarding of a same-character write.
   always_comb begin
      ex_valid_in = ex_valid_ff;
      if (queue_pop) begin
         ex_valid_in = 1'b1;
      end else if (ex_go) begin
         ex_valid_in = 1'b0;
      end
      fwd_in = ex_go && do_char && (queue_head.item.char_byte == ex_item_ff.char_byte);
      rsp_valid_in = rsp_valid_ff;
      if (ex_go && ex_item_ff.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff   <= 1'b0;
         pos_ff        <= '0;
         ws_ff         <= '0;
         best_start_ff <= '0;
         best_len_ff   <= '0;
         ovf_ff        <= 1'b0;
         seen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ex_valid_ff   <= ex_valid_in;
         pos_ff        <= pos_in;
         ws_ff         <= ws_in;
         best_start_ff <= best_start_in;
         best_len_ff   <= best_len_in;
         ovf_ff        <= ovf_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Table write from execute, registered read for the item entering it.
   always_ff @(posedge clock) begin
      if (ex_go && do_char) begin
         last_pos_mem[ex_item_ff.char_byte] <= pos_ff[LP_W-1:0];
      end
      if (queue_pop) begin
         rd_data_ff <= last_pos_mem[queue_head.item.char_byte];
         ex_item_ff <= queue_head.item;
         fwd_ff     <= fwd_in;
         fwd_pos_ff <= pos_ff[LP_W-1:0];
      end
   end

   // Result payload, masked to the field widths.
   always_ff @(posedge clock) begin
      if (ex_go && ex_item_ff.last) begin
         rsp_start_ff    <= START_W'(32'(final_start));
         rsp_length_ff   <= LEN_W'(32'(final_len));
         rsp_overflow_ff <= ovf_ff || (ex_item_ff.has_char && !in_range);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_start    = rsp_start_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_overflow = rsp_overflow_ff;
endmodule
`default_nettype wire

// ===== sv/longest_unique_run_finder_top.sv =====
// Top level of the longest unique run finder.
//
// The req channel takes a string one character per item; req_tlast marks the
// last item of a string. An item with req_tuser clear carries no character: it
// is ignored unless it is the last one, so it can end an empty string.
// For each string the rsp channel gives one item: the offset and length of the
// earliest longest run without a repeated byte, and an overflow flag when the
// string held more characters than the supported length (only the leading
// characters up to that length are examined then).
// Throughput is one item per cycle unless a string end waits for the result register:
// the per-character position table is read as an item enters execute, a write to the
// same character is forwarded, and the result is registered as the last item leaves.
// A four-entry queue sits between the front end and the table stage, so input
// items keep flowing while a result waits; when the receiver holds rsp_tready
// low the queue fills and req_tready drops.
// Reset clears all string state and the seen flags at once; the table itself
// is not cleared and no clearing pass is needed.
`default_nettype none
module longest_unique_run_finder_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // char_byte
   input  wire logic [0:0]                        req_tuser,  // has_char
   input  wire logic                              req_tlast,  // end_of_string
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [lurf_pkg::RSP_DATA_W-1:0]        rsp_tdata,  // run_start, run_length, zeros
   output logic [0:0]                             rsp_tuser   // overflow
);
   import lurf_pkg::*;

   lurf_queue_type     queue_head;
   logic               queue_pop;
   logic [START_W-1:0] run_start;
   logic [LEN_W-1:0]   run_length;
   logic               overflow;

   // Item intake and queue.
   lurf_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .in_char     (req_tdata),
      .in_has_char (req_tuser[0]),
      .in_last     (req_tlast),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop)
   );

   // Table stage and result register.
   lurf_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_head   (queue_head),
      .queue_pop    (queue_pop),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_start    (run_start),
      .rsp_length   (run_length),
      .rsp_overflow (overflow)
   );

   assign rsp_tdata = {{(RSP_DATA_W - START_W - LEN_W){1'b0}}, run_length, run_start};
   assign rsp_tuser = overflow;
endmodule
`default_nettype wire

// ===== sv/lurf_checker.sv =====
// Port-level checks for the longest unique run finder, bound to its top level.
`default_nettype none
module lurf_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [lurf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [0:0]                      rsp_tuser
);
   import lurf_pkg::*;

   // A stalled result holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result item changed while stalled");

   // No result is pending right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // An empty longest run always starts at offset zero.
   a_empty_start: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[START_W+LEN_W-1:START_W] == '0) |->
      (rsp_tdata[START_W-1:0] == '0))
      else $error("empty run with nonzero start");

   // An overflowed string saw characters, so its run is not empty.
   a_overflow_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[START_W+LEN_W-1:START_W] != '0))
      else $error("overflow reported with empty run");
endmodule

bind longest_unique_run_finder_top lurf_checker u_lurf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
`default_nettype wire
